// ----- sv/rilp_pkg.sv -----
package rilp_pkg;

   localparam int DEFAULT_MAX_LEN = 256;

   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_X          = 8'h78;
   localparam logic [7:0] CH_O          = 8'h6f;
   localparam logic [7:0] CH_B          = 8'h62;

   // digit class codes above the hex digits
   localparam logic [4:0] DIGIT_SUFFIX = 5'd16;
   localparam logic [4:0] DIGIT_OTHER  = 5'd17;

   typedef enum logic [1:0] {
      RADIX_2,
      RADIX_8,
      RADIX_10,
      RADIX_16
   } radix_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] value;
      logic        fits_signed;
      logic        has_suffix;
      logic [7:0]  suffix_start;
   } rsp_type;

   typedef struct packed {
      radix_type   radix;
      logic [63:0] accum;
      logic        saw_digit;
      logic        failed;
      logic        in_suffix;
      logic        first_was_zero;
      logic [7:0]  suffix_pos;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      radix:          RADIX_10,
      accum:          64'd0,
      saw_digit:      1'b0,
      failed:         1'b0,
      in_suffix:      1'b0,
      first_was_zero: 1'b0,
      suffix_pos:     8'd0
   };

   function automatic logic [4:0] radix_value(radix_type r);
      logic [4:0] v;
      case (r)
         RADIX_2:  v = 5'd2;
         RADIX_8:  v = 5'd8;
         RADIX_16: v = 5'd16;
         default:  v = 5'd10;
      endcase
      return v;
   endfunction

   function automatic logic [4:0] classify(logic [7:0] c);
      logic [4:0] d;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = 5'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = 5'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         d = DIGIT_SUFFIX;
      end else begin
         d = DIGIT_OTHER;
      end
      return d;
   endfunction

endpackage

// ----- sv/rilp_step.sv -----
module rilp_step
   import rilp_pkg::*;
#(
   parameter int MAX_LEN = DEFAULT_MAX_LEN,
   localparam int PosW = $clog2(MAX_LEN + 1)
) (
   input  parse_state_type cur_state,
   input  logic [PosW-1:0] cur_pos,
   input  req_type         item,
   output parse_state_type nxt_state,
   output logic [PosW-1:0] nxt_pos,
   output rsp_type         result
);

   logic [4:0]  digit;
   logic [67:0] acc_ext;
   logic [67:0] scaled;
   logic [67:0] sum;
   logic [31:0] pos_wide;
   logic        prefix_char;
   logic        good;

   assign digit       = classify(item.ch);
   assign acc_ext     = {4'd0, cur_state.accum};
   assign pos_wide    = 32'(cur_pos);
   assign prefix_char = (item.ch == CH_X) || (item.ch == CH_O) || (item.ch == CH_B);

   // multiply by the base as shifts, base ten as eight plus two
   always_comb begin
      case (cur_state.radix)
         RADIX_2:  scaled = acc_ext << 1;
         RADIX_8:  scaled = acc_ext << 3;
         RADIX_16: scaled = acc_ext << 4;
         default:  scaled = (acc_ext << 3) + (acc_ext << 1);
      endcase
   end

   assign sum = scaled + 68'(digit);

   always_comb begin
      nxt_state = cur_state;
      if (cur_pos >= PosW'(MAX_LEN)) begin
         nxt_state.failed = 1'b1;
      end else if (cur_pos == PosW'(1) && cur_state.first_was_zero && prefix_char &&
                   !cur_state.failed && !cur_state.in_suffix) begin
         // leading zero turns out to be a radix prefix
         if (item.ch == CH_X) begin
            nxt_state.radix = RADIX_16;
         end else if (item.ch == CH_O) begin
            nxt_state.radix = RADIX_8;
         end else begin
            nxt_state.radix = RADIX_2;
         end
         nxt_state.accum     = 64'd0;
         nxt_state.saw_digit = 1'b0;
      end else begin
         if (cur_pos == '0 && item.ch == CH_ZERO) begin
            nxt_state.first_was_zero = 1'b1;
         end
         if (!(cur_state.failed || cur_state.in_suffix || item.ch == CH_UNDERSCORE)) begin
            if (digit == DIGIT_SUFFIX) begin
               nxt_state.in_suffix  = 1'b1;
               nxt_state.suffix_pos = pos_wide[7:0];
            end else if (digit >= radix_value(cur_state.radix)) begin
               nxt_state.failed = 1'b1;
            end else begin
               nxt_state.saw_digit = 1'b1;
               if (|sum[67:64]) begin
                  nxt_state.failed = 1'b1;
               end else begin
                  nxt_state.accum = sum[63:0];
               end
            end
         end
      end
   end

   assign nxt_pos = (cur_pos < PosW'(MAX_LEN)) ? cur_pos + PosW'(1) : cur_pos;

   assign good                = !nxt_state.failed && nxt_state.saw_digit;
   assign result.ok           = good;
   assign result.value        = good ? nxt_state.accum : 64'd0;
   assign result.fits_signed  = good && !nxt_state.accum[63];
   assign result.has_suffix   = good && nxt_state.in_suffix;
   assign result.suffix_start = (good && nxt_state.in_suffix) ? nxt_state.suffix_pos : 8'd0;

endmodule

// ----- sv/radix_integer_literal_parser.sv -----
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_type: ch, last
// rsp       out        rsp_valid/rsp_stall  rsp_type: ok, value, fits_signed, has_suffix,
//                                           suffix_start
//
// one character item per cycle while req_stall is low; the parse state loop (base multiply,
// add and overflow check) closes through combinational logic alone
// a result item appears in the output register the cycle after its last character
// reset is synchronous and returns the parse state to base ten, empty
// req_stall follows a full output register that is itself stalled
module radix_integer_literal_parser
   import rilp_pkg::*;
#(
   parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   localparam int PosW = $clog2(MAX_LEN + 1);

   parse_state_type state_ff, state_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   parse_state_type step_state;
   logic [PosW-1:0] step_pos;
   rsp_type         step_result;
   logic            req_accept;

   // next state and result for the incoming character
   rilp_step #(
      .MAX_LEN (MAX_LEN)
   ) u_step (
      .cur_state (state_ff),
      .cur_pos   (pos_ff),
      .item      (req_item),
      .nxt_state (step_state),
      .nxt_pos   (step_pos),
      .result    (step_result)
   );

   // output register blocks input only when it holds an item nobody takes
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         if (req_item.last) begin
            // literal finished: hand over result and start afresh
            state_in     = STATE_RESET;
            pos_in       = '0;
            rsp_valid_in = 1'b1;
            rsp_in       = step_result;
         end else begin
            state_in = step_state;
            pos_in   = step_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // a last character always yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_item.last) |=> rsp_valid_ff)
      else $error("result missing after last character");

   // state is back to its start after a last character
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_item.last) |=> (pos_ff == '0 && !state_ff.failed &&
                                         !state_ff.saw_digit && state_ff.radix == RADIX_10))
      else $error("parse state not cleared after last character");

   // position counter saturates at the length limit
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosW'(MAX_LEN))
      else $error("position beyond length limit");

   // a failed parse leaves every field at zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.ok) |-> (rsp_ff.value == 64'd0 && !rsp_ff.fits_signed &&
                                        !rsp_ff.has_suffix && rsp_ff.suffix_start == 8'd0))
      else $error("failed parse with nonzero fields");

   // signed fit only for good values below two to the sixty-three
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.fits_signed) |-> (rsp_ff.ok && !rsp_ff.value[63]))
      else $error("fits_signed inconsistent with value");

endmodule

// ----- verif/tb_radix_integer_literal_parser.sv -----
`timescale 1ns / 1ps

module tb_radix_integer_literal_parser;
   import rilp_pkg::*;

   localparam int TEXT_LIMIT  = DEFAULT_MAX_LEN;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_CHARS = 360;

   // a failed parse clears every field
   localparam rsp_type NO_PARSE = '0;

   localparam byte unsigned CH_LOWER_A = "a";
   localparam byte unsigned CH_UPPER_A = "A";
   localparam byte unsigned CH_LOWER_G = "g";
   localparam byte unsigned CH_LOWER_K = "k";
   localparam byte unsigned CH_LOWER_Z = "z";
   localparam byte unsigned CH_SEVEN   = "7";

   typedef byte unsigned text_q[$];

   // one character on its way in, with the result typed in by hand where there is one
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } char_slot;

   typedef struct {
      string   text;
      bit      typed;
      rsp_type want;
   } directed_row;

   typedef enum {STALL_NONE, STALL_COIN, STALL_LONG, STALL_BEAT} stall_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   // literal state as the parser should hold it
   radix_type   lit_radix;
   logic [63:0] lit_accum;
   bit          lit_saw_digit;
   bit          lit_failed;
   bit          lit_in_suffix;
   bit          lit_first_zero;
   int unsigned lit_pos;
   logic [7:0]  lit_suffix_pos;

   char_slot stimulus_q[$];
   rsp_type  pending_results[$];
   int       mismatches = 0;

   // directed texts: every character class, prefix and suffix corners
   directed_row directed_rows[10] = '{
      '{"7",     1'b1, {1'b1, 64'd7, 1'b1, 1'b0, 8'd0}},
      '{"0",     1'b1, {1'b1, 64'd0, 1'b1, 1'b0, 8'd0}},
      '{"0x",    1'b1, NO_PARSE},   // prefix with no digit
      '{"9#",    1'b1, NO_PARSE},   // bad character
      '{"0b2",   1'b1, NO_PARSE},   // digit outside the base
      '{"_",     1'b1, NO_PARSE},   // separator only
      '{"Fz",    1'b1, NO_PARSE},   // hex letter in base ten
      '{"0b1_0", 1'b0, NO_PARSE},
      '{"0o7u8", 1'b0, NO_PARSE},   // suffix, trailing digit ignored
      '{"0xAf",  1'b0, NO_PARSE}
   };

   // values right at and just past the signed and unsigned limits
   string extreme_texts[8] = '{
      "18446744073709551615",
      "18446744073709551616",
      "9223372036854775807",
      "9223372036854775808",
      "0xffffffffffffffff",
      "0x1_0000_0000_0000_0000",
      "0x8000000000000000",
      "0o1777777777777777777777"
   };

   radix_integer_literal_parser #(
      .MAX_LEN(TEXT_LIMIT)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void clear_literal();
      lit_radix      = RADIX_10;
      lit_accum      = '0;
      lit_saw_digit  = 1'b0;
      lit_failed     = 1'b0;
      lit_in_suffix  = 1'b0;
      lit_first_zero = 1'b0;
      lit_pos        = 0;
      lit_suffix_pos = '0;
   endfunction

   // advance the literal state by one character; returns 1 when a result is due
   function automatic bit parse_literal_char(input req_type it, output rsp_type res);
      logic [4:0]  d;
      logic [63:0] base;
      bit          good;
      res = NO_PARSE;
      case (lit_radix)
         RADIX_2:  base = 64'd2;
         RADIX_8:  base = 64'd8;
         RADIX_16: base = 64'd16;
         default:  base = 64'd10;
      endcase
      if (lit_pos >= TEXT_LIMIT) begin
         lit_failed = 1'b1;
      end else if (lit_pos == 1 && lit_first_zero && !lit_failed && !lit_in_suffix &&
                   (it.ch == CH_X || it.ch == CH_O || it.ch == CH_B)) begin
         // the leading zero was a prefix after all
         lit_radix     = (it.ch == CH_X) ? RADIX_16 : (it.ch == CH_O) ? RADIX_8 : RADIX_2;
         lit_accum     = '0;
         lit_saw_digit = 1'b0;
      end else begin
         if (lit_pos == 0 && it.ch == CH_ZERO) begin
            lit_first_zero = 1'b1;
         end
         if (!(lit_failed || lit_in_suffix || it.ch == CH_UNDERSCORE)) begin
            if (it.ch >= "0" && it.ch <= "9") begin
               d = 5'(it.ch - CH_ZERO);
            end else if (it.ch >= CH_LOWER_A && it.ch <= "f") begin
               d = 5'(it.ch - CH_LOWER_A + 8'd10);
            end else if (it.ch >= CH_UPPER_A && it.ch <= "F") begin
               d = 5'(it.ch - CH_UPPER_A + 8'd10);
            end else if (it.ch >= CH_LOWER_A && it.ch <= CH_LOWER_Z) begin
               d = DIGIT_SUFFIX;
            end else begin
               d = DIGIT_OTHER;
            end
            if (d == DIGIT_SUFFIX) begin
               lit_in_suffix  = 1'b1;
               lit_suffix_pos = lit_pos[7:0];
            end else if (64'(d) >= base) begin
               lit_failed = 1'b1;
            end else begin
               lit_saw_digit = 1'b1;
               if (lit_accum > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / base) begin
                  lit_failed = 1'b1;
               end else begin
                  lit_accum = lit_accum * base + 64'(d);
               end
            end
         end
      end
      if (lit_pos < TEXT_LIMIT) begin
         lit_pos++;
      end
      if (!it.last) begin
         return 1'b0;
      end
      good = !lit_failed && lit_saw_digit;
      if (good) begin
         res.ok           = 1'b1;
         res.value        = lit_accum;
         res.fits_signed  = !lit_accum[63];
         res.has_suffix   = lit_in_suffix;
         res.suffix_start = lit_in_suffix ? lit_suffix_pos : 8'd0;
      end
      clear_literal();
      return 1'b1;
   endfunction

   function automatic text_q to_bytes(string s);
      text_q q;
      for (int i = 0; i < s.len(); i++) begin
         q.push_back(s[i]);
      end
      return q;
   endfunction

   // split a text into items, the final one marked last
   task automatic queue_literal(input text_q txt, input bit typed, input rsp_type want);
      char_slot slot;
      foreach (txt[i]) begin
         slot.item.ch   = txt[i];
         slot.item.last = (i == txt.size() - 1);
         slot.typed     = typed;
         slot.want      = want;
         stimulus_q.push_back(slot);
      end
   endtask

   // one random literal: mostly well formed, some broken, some plain noise
   task automatic queue_random_literal();
      text_q txt;
      int    kind;
      int    base;
      int    n;
      int    d;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         txt = to_bytes(extreme_texts[$urandom_range(0, 7)]);
      end else if (kind < 85) begin
         case ($urandom_range(0, 3))
            0: begin base = 2;  txt = to_bytes("0b"); n = 66; end
            1: begin base = 8;  txt = to_bytes("0o"); n = 24; end
            2: begin base = 16; txt = to_bytes("0x"); n = 18; end
            default: begin base = 10; n = 21; end
         endcase
         // long digit runs are rarer, they probe the overflow edge
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
               txt.push_back(CH_UNDERSCORE);
            end
            d = $urandom_range(0, base - 1);
            if (d < 10) begin
               txt.push_back(8'(CH_ZERO + d));
            end else begin
               txt.push_back(8'(($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + d - 10));
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            txt.push_back(8'($urandom_range(CH_LOWER_G, CH_LOWER_Z)));
            repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom_range(0, 255)));
         end
         // broken sequence: one character swapped for any byte
         if (kind >= 70) begin
            txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
         end
      end else begin
         repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
      end
      queue_literal(txt, 1'b0, NO_PARSE);
   endtask

   // sender: builds the stimulus, then drives it in bursts, predicting on each accepted item
   initial begin : sender
      char_slot cur;
      rsp_type  res;
      text_q    txt;
      int       burst_left;
      int       gap_left;
      int       first_random;
      clear_literal();
      foreach (directed_rows[i]) begin
         queue_literal(to_bytes(directed_rows[i].text), directed_rows[i].typed,
                       directed_rows[i].want);
      end
      // longest text that still parses, suffix on the very last position
      txt.push_back(CH_SEVEN);
      repeat (TEXT_LIMIT - 2) txt.push_back(CH_UNDERSCORE);
      txt.push_back(CH_LOWER_K);
      queue_literal(txt, 1'b0, NO_PARSE);
      // one character too many
      txt.delete();
      txt.push_back(CH_SEVEN);
      repeat (TEXT_LIMIT) txt.push_back(CH_UNDERSCORE);
      queue_literal(txt, 1'b0, NO_PARSE);
      first_random = stimulus_q.size();
      while (stimulus_q.size() - first_random < RANDOM_CHARS) begin
         queue_random_literal();
      end

      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
      do @(posedge clock); while (reset);
      while (stimulus_q.size() != 0 || req_valid) begin
         if (req_valid && !req_stall) begin
            if (parse_literal_char(cur.item, res)) begin
               pending_results.push_back(cur.typed ? cur.want : res);
            end
         end
         // a stalled item stays put until it is taken
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || stimulus_q.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0) begin
                  gap_left--;
               end
            end else begin
               cur = stimulus_q.pop_front();
               req_valid <= 1'b1;
               req_item  <= cur.item;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  // about a quarter of bursts run straight into the next
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
         end
         @(posedge clock);
      end
      while (pending_results.size() != 0) @(posedge clock);
      // catch any stray result behind the last one
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("radix_integer_literal_parser: match");
      end else begin
         $display("radix_integer_literal_parser: mismatch");
      end
      $finish;
   end

   // receiver stall pattern: changes character whenever its phase counter runs out
   always @(posedge clock) begin : stall_pattern
      static stall_mode_type stall_mode = STALL_NONE;
      static int             stall_phase = 0;
      static int             hold_left = 0;
      if (stall_phase == 0) begin
         stall_mode  = stall_mode_type'($urandom_range(0, 3));
         stall_phase = $urandom_range(16, 80);
      end else begin
         stall_phase--;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_COIN: rsp_stall <= 1'($urandom_range(0, 1));
         STALL_LONG: begin
            if (hold_left > 0) begin
               rsp_stall <= 1'b1;
               hold_left--;
            end else begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 9) == 0) begin
                  hold_left = $urandom_range(1, 15);
               end
            end
         end
         default: rsp_stall <= !rsp_stall;
      endcase
   end

   // every result taken is compared with the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: ok %0b value %h", rsp_item.ok, rsp_item.value);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.ok !== want.ok || rsp_item.value !== want.value ||
                rsp_item.fits_signed !== want.fits_signed ||
                rsp_item.has_suffix !== want.has_suffix ||
                rsp_item.suffix_start !== want.suffix_start) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result differs (expected/actual): ok %0b/%0b value %h/%h",
                           want.ok, rsp_item.ok, want.value, rsp_item.value);
                  $display("   fits %0b/%0b suffix %0b/%0b at %0d/%0d",
                           want.fits_signed, rsp_item.fits_signed,
                           want.has_suffix, rsp_item.has_suffix,
                           want.suffix_start, rsp_item.suffix_start);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("radix_integer_literal_parser: mismatch");
      $finish;
   end

endmodule

// ----- radix_integer_literal_parser.f -----
sv/rilp_pkg.sv
sv/rilp_step.sv
sv/radix_integer_literal_parser.sv
verif/tb_radix_integer_literal_parser.sv
